FILE: rtl/core/drlt_pkg.sv
`default_nettype none
package drlt_pkg;

  // Operation codes of the input channel
  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Largest coordinate a stored rectangle may start at
  localparam logic signed [17:0] COORD_MAX = 18'sd32767;

  // Stored list entry, 62 bits
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } entry_t;

  // Piece in flight; corners may run past the 16-bit range
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } piece_t;

  // Split result: push flags and pieces, index 0 bottom, 1 top, 2 right, 3 left
  typedef struct packed {
    logic             hit;
    logic [3:0]       push;
    piece_t [3:0]     pc;
  } split_t;

endpackage
`default_nettype wire

FILE: rtl/core/drlt_ram.sv
`default_nettype none
module drlt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/drlt_split.sv
`default_nettype none
module drlt_split (
  input  wire drlt_pkg::piece_t p_i,
  input  wire drlt_pkg::entry_t d_i,
  output drlt_pkg::split_t      res_o
);

  logic signed [17:0] dx, dy, pw, ph, dw, dh;
  logic signed [17:0] pr, pb, dr, db, ty, bot, th;
  logic               hit;

  // Edges of the piece and the stored entry
  always_comb begin
    dx  = {{2{d_i.x[15]}}, d_i.x};
    dy  = {{2{d_i.y[15]}}, d_i.y};
    pw  = $signed({3'b000, p_i.w});
    ph  = $signed({3'b000, p_i.h});
    dw  = $signed({3'b000, d_i.w});
    dh  = $signed({3'b000, d_i.h});
    pr  = p_i.x + pw;
    pb  = p_i.y + ph;
    dr  = dx + dw;
    db  = dy + dh;
    hit = (dx < pr) && (dr > p_i.x) && (dy < pb) && (db > p_i.y);
    ty  = (p_i.y > dy) ? p_i.y : dy;
    bot = (pb < db) ? pb : db;
    th  = bot - ty;
  end

  // Remainder pieces around the overlap
  always_comb begin
    res_o.hit     = hit;
    res_o.push[0] = hit && (db < pb);
    res_o.push[1] = hit && (dy > p_i.y);
    res_o.push[2] = hit && (dr < pr);
    res_o.push[3] = hit && (dx > p_i.x);
    res_o.pc[0]   = '{x: p_i.x, y: db, w: p_i.w, h: 15'(pb - db)};
    res_o.pc[1]   = '{x: p_i.x, y: p_i.y, w: p_i.w, h: 15'(dy - p_i.y)};
    res_o.pc[2]   = '{x: dr, y: ty, w: 15'(pr - dr), h: 15'(th)};
    res_o.pc[3]   = '{x: p_i.x, y: ty, w: 15'(dx - p_i.x), h: 15'(th)};
  end

endmodule
`default_nettype wire

FILE: rtl/core/dirty_rect_list_tracker.sv
`default_nettype none
// Dirty rectangle list tracker. Keeps up to LIST_CAPACITY non-overlapping
// rectangles in a block RAM and subtracts them from each marked rectangle with
// one shared overlap/split unit, walking the stored list one entry at a time
// (RAM read, then compare). Remainder pieces go on a pending stack held
// in a second RAM; a split steps through its four remainder slots in S_PUSH,
// and a pop reads the stack RAM in S_POP and takes the piece in S_POPW. Each
// piece is range checked and popped, compared with each entry scanned, and
// then split or appended, so a mark is data dependent and grows with the list
// length and the number of pieces; a read fetches one entry from the RAM.
// One transaction is worked at a time: in_stall_o stays high until the result
// has left the output register. Every result carries the entry count, the
// saturating covered area and the full-redraw flag.
module dirty_rect_list_tracker #(
  parameter int LIST_CAPACITY = 256,
  parameter int PENDING_DEPTH = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [15:0] rect_left_i,
  input  wire logic signed [15:0] rect_top_i,
  input  wire logic [14:0]        rect_width_i,
  input  wire logic [14:0]        rect_height_i,
  input  wire logic [7:0]         entry_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      out_left_o,
  output logic signed [15:0]      out_top_o,
  output logic [14:0]             out_width_o,
  output logic [14:0]             out_height_o,
  output logic [8:0]              entry_count_o,
  output logic [39:0]             covered_area_o,
  output logic                    full_redraw_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [39:0]        cfg_data_i
);

  localparam int AW  = $clog2(LIST_CAPACITY);
  localparam int CW  = $clog2(LIST_CAPACITY + 1);
  localparam int SAW = $clog2(PENDING_DEPTH);
  localparam int TW  = $clog2(PENDING_DEPTH + 1);
  localparam int EW  = $bits(drlt_pkg::entry_t);
  localparam int PW  = $bits(drlt_pkg::piece_t);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHECK    = 10'b0000000010,
    S_POP      = 10'b0000000100,
    S_POPW     = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_CMP = 10'b0000100000,
    S_PUSH     = 10'b0001000000,
    S_APPEND   = 10'b0010000000,
    S_AREA     = 10'b0100000000,
    S_RDW      = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [39:0]        area_q, area_d;
  logic [39:0]        limit_q;
  logic [TW-1:0]      top_q, top_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [1:0]         step_q, step_d;
  logic [29:0]        prod_q, prod_d;
  logic [7:0]         rd_idx_q, rd_idx_d;
  drlt_pkg::piece_t   p_q, p_d;
  logic               out_valid_q, out_valid_d;
  drlt_pkg::entry_t   out_q, out_d;

  logic               in_acc;
  logic               st_we, st_re, sk_we, sk_re;
  logic [AW-1:0]      st_waddr, st_raddr;
  logic [SAW-1:0]     sk_waddr, sk_raddr;
  drlt_pkg::entry_t   st_wdata, st_rdata;
  drlt_pkg::piece_t   sk_wdata, sk_rdata;
  logic [EW-1:0]      st_rdata_raw;
  logic [PW-1:0]      sk_rdata_raw;
  drlt_pkg::split_t   split;
  logic [40:0]        area_sum;
  logic               list_full, stack_full;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign st_rdata    = drlt_pkg::entry_t'(st_rdata_raw);
  assign sk_rdata    = drlt_pkg::piece_t'(sk_rdata_raw);
  assign list_full   = count_q >= CW'(LIST_CAPACITY);
  assign stack_full  = top_q == TW'(PENDING_DEPTH);
  assign area_sum    = {1'b0, area_q} + 41'(prod_q);

  drlt_ram #(.WIDTH(EW), .DEPTH(LIST_CAPACITY)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata_raw)
  );

  drlt_ram #(.WIDTH(PW), .DEPTH(PENDING_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .re_i    (sk_re),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata_raw)
  );

  drlt_split u_split (
    .p_i   (p_q),
    .d_i   (st_rdata),
    .res_o (split)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    area_d      = area_q;
    top_d       = top_q;
    idx_d       = idx_q;
    step_d      = step_q;
    prod_d      = prod_q;
    rd_idx_d    = rd_idx_q;
    p_d         = p_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    st_we       = 1'b0;
    st_waddr    = count_q[AW-1:0];
    st_wdata    = '{x: p_q.x[15:0], y: p_q.y[15:0], w: p_q.w, h: p_q.h};
    st_re       = 1'b0;
    st_raddr    = idx_q[AW-1:0];
    sk_we       = 1'b0;
    sk_waddr    = top_q[SAW-1:0];
    sk_wdata    = split.pc[step_q];
    sk_re       = 1'b0;
    sk_raddr    = SAW'(top_q - TW'(1));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_d = '0;
          case (drlt_pkg::op_e'(opcode_i))
            drlt_pkg::OP_MARK: begin
              if (rect_width_i == '0 && rect_height_i == '0) begin
                out_valid_d = 1'b1;
              end else begin
                p_d = '{x: {{2{rect_left_i[15]}}, rect_left_i},
                        y: {{2{rect_top_i[15]}}, rect_top_i},
                        w: rect_width_i, h: rect_height_i};
                top_d   = '0;
                state_d = S_CHECK;
              end
            end
            drlt_pkg::OP_READ: begin
              st_re    = 1'b1;
              st_raddr = AW'(entry_index_i);
              rd_idx_d = entry_index_i;
              state_d  = S_RDW;
            end
            drlt_pkg::OP_CLEAR: begin
              count_d     = '0;
              area_d      = '0;
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        idx_d = '0;
        if (list_full || p_q.x > drlt_pkg::COORD_MAX || p_q.y > drlt_pkg::COORD_MAX) begin
          state_d = S_POP;
        end else if (count_q == '0) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_POP: begin
        if (top_q == '0) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          sk_re   = 1'b1;
          top_d   = top_q - TW'(1);
          state_d = S_POPW;
        end
      end
      S_POPW: begin
        p_d     = sk_rdata;
        state_d = S_CHECK;
      end
      S_SCAN_RD: begin
        st_re   = 1'b1;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (split.hit) begin
          step_d  = '0;
          state_d = S_PUSH;
        end else if (idx_q + CW'(1) == count_q) begin
          state_d = S_APPEND;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SCAN_RD;
        end
      end
      // Bottom, top, right, left: left ends up on top of the stack
      S_PUSH: begin
        if (split.push[step_q] && !stack_full) begin
          sk_we = 1'b1;
          top_d = top_q + TW'(1);
        end
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_POP;
        end
      end
      S_APPEND: begin
        st_we   = 1'b1;
        count_d = count_q + CW'(1);
        prod_d  = 30'(p_q.w) * 30'(p_q.h);
        state_d = S_AREA;
      end
      S_AREA: begin
        area_d  = area_sum[40] ? '1 : area_sum[39:0];
        state_d = S_POP;
      end
      S_RDW: begin
        if (12'(rd_idx_q) < 12'(count_q)) begin
          out_d = st_rdata;
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      area_q      <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      limit_q     <= 40'd230400;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      area_q      <= area_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    step_q   <= step_d;
    prod_q   <= prod_d;
    rd_idx_q <= rd_idx_d;
    p_q      <= p_d;
    out_q    <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_left_o     = out_q.x;
  assign out_top_o      = out_q.y;
  assign out_width_o    = out_q.w;
  assign out_height_o   = out_q.h;
  assign entry_count_o  = 9'(count_q);
  assign covered_area_o = area_q;
  assign full_redraw_o  = list_full || (area_q > limit_q);

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(PENDING_DEPTH))
    else $error("pending stack pointer past depth");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_CAPACITY))
    else $error("entry count past capacity");
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPEND |-> !list_full)
    else $error("append into a full list");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_IDLE) && (top_q == '0 || !$past(state_q == S_POP)))
    else $error("result presented while sequencer busy");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;

  localparam int CAPACITY    = 256;
  localparam int STACK_DEPTH = 1024;
  localparam int COORD_TOP   = 32767;
  localparam longint unsigned AREA_MAX = 64'hFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int RANDOM_ITEMS = 850;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } box_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [8:0]         count;
    logic [39:0]        area;
    logic               full;
  } status_t;

  // Keeps its own rectangle list and the queue of results still owed
  class rect_list_scoreboard;
    box_t            stored[$];
    longint unsigned area_sum;
    logic [39:0]     area_limit;
    status_t         owed[$];
    int              errors;

    function new();
      area_sum   = 0;
      area_limit = 40'd230400;
      errors     = 0;
    endfunction

    // Subtract stored entries from the new rectangle, depth first
    function void subtract_and_append(int x0, int y0, int w0, int h0);
      box_t pend[$];
      box_t p, d, n;
      int pr, pb, dr, db, ty, th;
      bit hit;
      n = '{x0, y0, w0, h0};
      pend.push_back(n);
      while (pend.size() > 0) begin
        p = pend.pop_back();
        if (stored.size() >= CAPACITY) continue;
        if (p.x > COORD_TOP || p.y > COORD_TOP) continue;
        hit = 0;
        for (int i = 0; i < stored.size(); i++) begin
          d  = stored[i];
          pr = p.x + p.w;
          pb = p.y + p.h;
          dr = d.x + d.w;
          db = d.y + d.h;
          if (d.x < pr && dr > p.x && d.y < pb && db > p.y) begin
            ty = (p.y > d.y) ? p.y : d.y;
            th = ((pb < db) ? pb : db) - ty;
            // bottom, top, right, left: left comes off the stack first
            if (db < pb && pend.size() < STACK_DEPTH) begin
              n = '{p.x, db, p.w, pb - db}; pend.push_back(n);
            end
            if (d.y > p.y && pend.size() < STACK_DEPTH) begin
              n = '{p.x, p.y, p.w, d.y - p.y}; pend.push_back(n);
            end
            if (dr < pr && pend.size() < STACK_DEPTH) begin
              n = '{dr, ty, pr - dr, th}; pend.push_back(n);
            end
            if (d.x > p.x && pend.size() < STACK_DEPTH) begin
              n = '{p.x, ty, d.x - p.x, th}; pend.push_back(n);
            end
            hit = 1;
            break;
          end
        end
        if (!hit) begin
          stored.push_back(p);
          area_sum += longint'(p.w) * longint'(p.h);
          if (area_sum > AREA_MAX) area_sum = AREA_MAX;
        end
      end
    endfunction

    function void note_input(drlt_pkg::op_e op, int x, int y, int w, int h, int idx);
      status_t r;
      // Fields as the ports carry them
      x   = int'($signed(x[15:0]));
      y   = int'($signed(y[15:0]));
      w   = w & 32'h7FFF;
      h   = h & 32'h7FFF;
      idx = idx & 32'hFF;
      r = '{default: '0};
      case (op)
        drlt_pkg::OP_MARK: begin
          if (!(w == 0 && h == 0)) subtract_and_append(x, y, w, h);
        end
        drlt_pkg::OP_READ: begin
          if (idx < stored.size()) begin
            r.left   = stored[idx].x;
            r.top    = stored[idx].y;
            r.width  = stored[idx].w;
            r.height = stored[idx].h;
          end
        end
        drlt_pkg::OP_CLEAR: begin
          stored.delete();
          area_sum = 0;
        end
        default: ;
      endcase
      r.count = stored.size();
      r.area  = area_sum[39:0];
      r.full  = (stored.size() >= CAPACITY) || (area_sum[39:0] > area_limit);
      owed.push_back(r);
    endfunction

    function void compare(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(status_t act);
      status_t e;
      if (owed.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = owed.pop_front();
      compare("out_left", e.left, act.left);
      compare("out_top", e.top, act.top);
      compare("out_width", e.width, act.width);
      compare("out_height", e.height, act.height);
      compare("entry_count", e.count, act.count);
      compare("covered_area", e.area, act.area);
      compare("full_redraw", e.full, act.full);
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic [1:0]         opcode_i = '0;
  logic signed [15:0] rect_left_i = '0;
  logic signed [15:0] rect_top_i = '0;
  logic [14:0]        rect_width_i = '0;
  logic [14:0]        rect_height_i = '0;
  logic [7:0]         entry_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [15:0] out_left_o;
  logic signed [15:0] out_top_o;
  logic [14:0]        out_width_o;
  logic [14:0]        out_height_o;
  logic [8:0]         entry_count_o;
  logic [39:0]        covered_area_o;
  logic               full_redraw_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [39:0]        cfg_data_i = '0;

  rect_list_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  dirty_rect_list_tracker dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .opcode_i, .rect_left_i, .rect_top_i, .rect_width_i, .rect_height_i, .entry_index_i,
    .out_valid_o, .out_stall_i,
    .out_left_o, .out_top_o, .out_width_o, .out_height_o,
    .entry_count_o, .covered_area_o, .full_redraw_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: check each transaction, stall on a shifting pattern
  always @(posedge clk_i) begin
    status_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act = '{out_left_o, out_top_o, out_width_o, out_height_o,
              entry_count_o, covered_area_o, full_redraw_o};
      sb.check_result(act);
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt = 500;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      case ((cycles / 97) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= $urandom_range(0, 1);
        2: out_stall_i <= (cycles % 5) < 3;
        default: out_stall_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offer one transaction; random bursts and gaps between them
  task automatic send_item(drlt_pkg::op_e op, int x, int y, int w, int h, int idx);
    int gap;
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    rect_left_i   <= x;
    rect_top_i    <= y;
    rect_width_i  <= w;
    rect_height_i <= h;
    entry_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, x, y, w, h, idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic mark(int x, int y, int w, int h);
    send_item(drlt_pkg::OP_MARK, x, y, w, h, $urandom_range(0, 255));
  endtask

  task automatic read_entry(int idx);
    send_item(drlt_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, idx);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.owed.size() != 0);
  endtask

  // Register write, only once the block has gone idle
  task automatic write_limit(logic [39:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.area_limit = value;
  endtask

  task automatic random_item(ref int sent);
    int r, n;
    r = $urandom_range(0, 99);
    n = sb.stored.size();
    if (r < 2) begin
      send_item(drlt_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 4) begin
      send_item(drlt_pkg::OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 5) begin
      mark($urandom, $urandom, 0, 0);
      return;
    end else if (r < 20) begin
      read_entry((n > 0 && r < 17) ? $urandom_range(0, n - 1) : $urandom_range(0, 255));
    end else if (r < 27) begin
      mark($urandom, $urandom, $urandom_range(0, 32767), $urandom_range(0, 32767));
    end else begin
      // crowded region so pieces split and the list fills up
      mark($urandom_range(0, 300) - 20, $urandom_range(0, 300) - 20,
           $urandom_range(0, 60), $urandom_range(1, 60));
    end
    sent++;
  endtask

  initial begin
    int sent;
    logic [39:0] limits[4];
    limits = '{40'd0, 40'hFF_FFFF_FFFF, 40'd5000, 40'd0};
    limits[3] = {$urandom_range(0, 255), $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: splits, empty and thin marks, off-range pieces, reads, clear
    mark(10, 10, 20, 20);
    mark(0, 0, 0, 0);
    mark(15, 15, 20, 20);
    mark(5, 5, 40, 40);
    mark(100, 100, 0, 5);
    mark(200, 200, 7, 0);
    mark(-32768, -32768, 32767, 32767);
    mark(32000, 0, 1000, 10);
    mark(32500, 0, 32767, 10);
    mark(0, 32000, 10, 1000);
    mark(0, 32500, 10, 32767);
    mark(32767, 32767, 32767, 32767);
    read_entry(0);
    read_entry(3);
    read_entry(sb.stored.size());
    read_entry(255);
    send_item(drlt_pkg::OP_NOP, -1, -1, 32767, 32767, 255);
    send_item(drlt_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    read_entry(0);
    mark(-1, -1, 32767, 32767);

    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        if (ph == 1 && sent == RANDOM_ITEMS / 4 + 50) hold_seq++;
        random_item(sent);
      end
    end
    write_limit(40'd230400);
    repeat (40) random_item(sent);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
